[rtl/vnat_pkg.sv]
// ----------------------------------------------------------------------------
// Voice note attack tracker package
// Shared types, register indexes and reset constants for the tracker.
// ----------------------------------------------------------------------------
package vnat_pkg;

  localparam int unsigned VOICE_SLOTS_DEF = 4;

  localparam logic signed [15:0] CHUNK_MIN_RESET = 16'sh7fff;
  localparam logic signed [15:0] CHUNK_MAX_RESET = -16'sh8000;
  localparam logic [7:0]         AMP_LIMIT       = 8'd255;
  localparam int unsigned        SWING_SHIFT     = 14;

  typedef enum logic [1:0] {
    CFG_USE_SWING        = 2'd0,
    CFG_VOICE_COUNT      = 2'd1,
    CFG_ATTACK_THRESHOLD = 2'd2,
    CFG_RELEASE_STEP     = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    ACT_TRACE_SAMPLE = 1'b0,
    ACT_CHUNK_END    = 1'b1
  } action_e;

  typedef struct packed {
    logic              action;
    logic [1:0]        voice;
    logic signed [15:0] trace_sample;
    logic              gate;
    logic [31:0]       sample_address;
    logic [7:0]        register_volume;
    logic [15:0]       pitch_value;
    logic              muted;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  voice_out;
    logic [15:0] note_pitch;
    logic [7:0]  note_volume;
    logic [7:0]  note_counter;
    logic        retriggered;
  } out_item_t;

  typedef struct packed {
    logic       use_swing;
    logic [2:0] voice_count;
    logic [7:0] attack_threshold;
    logic [7:0] release_step;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] cmin;
    logic signed [15:0] cmax;
    logic               seen;
  } chunk_rec_t;

  typedef struct packed {
    logic [7:0]  envelope;
    logic        prev_gate;
    logic [31:0] prev_address;
    logic [7:0]  generation;
  } voice_rec_t;

  typedef struct packed {
    logic chunk_we;
    logic voice_we;
    logic res_valid;
  } upd_ctrl_t;

  localparam chunk_rec_t CHUNK_RESET = '{
    cmin: CHUNK_MIN_RESET,
    cmax: CHUNK_MAX_RESET,
    seen: 1'b0
  };

  localparam voice_rec_t VOICE_RESET = '{
    envelope:     8'd0,
    prev_gate:    1'b0,
    prev_address: 32'd0,
    generation:   8'd0
  };

endpackage

[rtl/vnat_ram.sv]
// ----------------------------------------------------------------------------
// Voice note attack tracker RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module vnat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/vnat_update.sv]
// ----------------------------------------------------------------------------
// Voice note attack tracker update
// Computes the new per-voice records and the report for one item.
// ----------------------------------------------------------------------------
module vnat_update import vnat_pkg::*; (
  input  cfg_t       cfg_i,
  input  in_item_t   item_i,
  input  chunk_rec_t chunk_i,
  input  voice_rec_t voice_i,
  output upd_ctrl_t  ctrl_o,
  output chunk_rec_t chunk_o,
  output voice_rec_t voice_o,
  output out_item_t  res_o
);

  logic        active;
  logic [16:0] swing;
  logic [24:0] scaled;
  logic [10:0] quot;
  logic [7:0]  amp;
  logic [8:0]  env_limit;
  logic        retrig;
  logic [7:0]  floor_val;
  logic [7:0]  env_new;

  assign active = ({1'b0, item_i.voice} < cfg_i.voice_count);

  always_comb begin
    swing = chunk_i.seen
      ? ({chunk_i.cmax[15], chunk_i.cmax} - {chunk_i.cmin[15], chunk_i.cmin}) : 17'd0;
    scaled = {swing, 8'd0} - {8'd0, swing};
    quot   = scaled[24:SWING_SHIFT];
    amp    = 8'd0;
    if (item_i.gate) begin
      if (cfg_i.use_swing) begin
        amp = (quot > {3'd0, AMP_LIMIT}) ? AMP_LIMIT : quot[7:0];
      end else begin
        amp = item_i.register_volume;
      end
    end
    env_limit = {1'b0, voice_i.envelope} + {1'b0, cfg_i.attack_threshold};
    retrig = item_i.gate && (!voice_i.prev_gate
                             || (item_i.sample_address != voice_i.prev_address)
                             || ({1'b0, amp} > env_limit));
    floor_val = (voice_i.envelope > cfg_i.release_step)
      ? (voice_i.envelope - cfg_i.release_step) : 8'd0;
    priority if (retrig || (amp == 8'd0)) begin
      env_new = amp;
    end else if (amp >= voice_i.envelope) begin
      env_new = voice_i.envelope;
    end else begin
      env_new = (amp > floor_val) ? amp : floor_val;
    end
  end

  always_comb begin
    ctrl_o  = '0;
    chunk_o = chunk_i;
    voice_o = voice_i;
    unique case (action_e'(item_i.action))
      ACT_TRACE_SAMPLE: begin
        ctrl_o.chunk_we = 1'b1;
        if (item_i.trace_sample < chunk_i.cmin) begin
          chunk_o.cmin = item_i.trace_sample;
        end
        if (item_i.trace_sample > chunk_i.cmax) begin
          chunk_o.cmax = item_i.trace_sample;
        end
        chunk_o.seen = 1'b1;
      end
      ACT_CHUNK_END: begin
        if (active) begin
          ctrl_o.chunk_we  = 1'b1;
          ctrl_o.voice_we  = 1'b1;
          ctrl_o.res_valid = 1'b1;
          chunk_o          = CHUNK_RESET;
          voice_o.envelope     = env_new;
          voice_o.prev_gate    = item_i.gate;
          voice_o.prev_address = item_i.sample_address;
          voice_o.generation   = retrig ? (voice_i.generation + 8'd1) : voice_i.generation;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.voice_out    = item_i.voice;
    res_o.note_pitch   = item_i.muted ? 16'd0 : item_i.pitch_value;
    res_o.note_volume  = item_i.muted ? 8'd0 : env_new;
    res_o.note_counter = voice_o.generation;
    res_o.retriggered  = retrig;
  end

endmodule

[rtl/voice_note_attack_tracker_top.sv]
// ----------------------------------------------------------------------------
// Voice note attack tracker
// A chunk end report passes the stage register and then the output register.
// Throughput: one item per cycle while out_ready does not hold a report; each
// item is read from the voice RAMs in the cycle it is taken and written back
// when it leaves the stage, with forwarding of the last write. Reset clears the
// configuration to defaults and marks all RAM entries as holding their reset values; items are taken right after reset.
// ----------------------------------------------------------------------------
module voice_note_attack_tracker_top import vnat_pkg::*; #(
  parameter int unsigned VOICE_SLOTS = VOICE_SLOTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  localparam int unsigned AddrW = (VOICE_SLOTS > 1) ? $clog2(VOICE_SLOTS) : 1;
  localparam int unsigned ChunkW = $bits(chunk_rec_t);
  localparam int unsigned VoiceW = $bits(voice_rec_t);

  cfg_t cfg_q;

  logic             s1_valid_q;
  in_item_t         s1_item_q;
  logic [AddrW-1:0] s1_addr_q;

  logic [VOICE_SLOTS-1:0] c_valid_q;
  logic [VOICE_SLOTS-1:0] v_valid_q;

  logic             fwd_c_valid_q;
  logic [AddrW-1:0] fwd_c_addr_q;
  chunk_rec_t       fwd_c_q;
  logic             fwd_v_valid_q;
  logic [AddrW-1:0] fwd_v_addr_q;
  voice_rec_t       fwd_v_q;

  logic      out_valid_q;
  out_item_t out_q;

  logic             in_accept;
  logic             slot_ok;
  logic [AddrW-1:0] rd_addr;
  logic [ChunkW-1:0] c_rdata;
  logic [VoiceW-1:0] v_rdata;
  chunk_rec_t       chunk_cur;
  voice_rec_t       voice_cur;
  upd_ctrl_t        ctrl;
  chunk_rec_t       chunk_new;
  voice_rec_t       voice_new;
  out_item_t        res;
  logic             s1_adv;
  logic             s1_fire;
  logic             c_we;
  logic             v_we;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_swing        <= 1'b1;
      cfg_q.voice_count      <= 3'd3;
      cfg_q.attack_threshold <= 8'd24;
      cfg_q.release_step     <= 8'd3;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_USE_SWING:        cfg_q.use_swing        <= cfg_data_i[0];
        CFG_VOICE_COUNT:      cfg_q.voice_count      <= cfg_data_i[2:0];
        CFG_ATTACK_THRESHOLD: cfg_q.attack_threshold <= cfg_data_i;
        CFG_RELEASE_STEP:     cfg_q.release_step     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign slot_ok   = (32'(in_item_i.voice) < VOICE_SLOTS);
  assign rd_addr   = AddrW'(in_item_i.voice);
  assign in_accept = in_valid_i && in_ready_o;

  vnat_ram #(.Width(ChunkW), .Depth(VOICE_SLOTS)) u_chunk_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (s1_addr_q),
    .wdata_i (chunk_new),
    .re_i    (in_accept),
    .raddr_i (rd_addr),
    .rdata_o (c_rdata)
  );

  vnat_ram #(.Width(VoiceW), .Depth(VOICE_SLOTS)) u_voice_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (s1_addr_q),
    .wdata_i (voice_new),
    .re_i    (in_accept),
    .raddr_i (rd_addr),
    .rdata_o (v_rdata)
  );

  always_comb begin
    priority if (fwd_c_valid_q && (fwd_c_addr_q == s1_addr_q)) begin
      chunk_cur = fwd_c_q;
    end else if (c_valid_q[s1_addr_q]) begin
      chunk_cur = chunk_rec_t'(c_rdata);
    end else begin
      chunk_cur = CHUNK_RESET;
    end
    priority if (fwd_v_valid_q && (fwd_v_addr_q == s1_addr_q)) begin
      voice_cur = fwd_v_q;
    end else if (v_valid_q[s1_addr_q]) begin
      voice_cur = voice_rec_t'(v_rdata);
    end else begin
      voice_cur = VOICE_RESET;
    end
  end

  vnat_update u_update (
    .cfg_i   (cfg_q),
    .item_i  (s1_item_q),
    .chunk_i (chunk_cur),
    .voice_i (voice_cur),
    .ctrl_o  (ctrl),
    .chunk_o (chunk_new),
    .voice_o (voice_new),
    .res_o   (res)
  );

  assign s1_adv     = !ctrl.res_valid || !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign c_we       = s1_fire && ctrl.chunk_we;
  assign v_we       = s1_fire && ctrl.voice_we;
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      c_valid_q     <= '0;
      v_valid_q     <= '0;
      fwd_c_valid_q <= 1'b0;
      fwd_v_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i && slot_ok;
      end
      if (c_we) begin
        c_valid_q[s1_addr_q] <= 1'b1;
        fwd_c_valid_q        <= 1'b1;
      end
      if (v_we) begin
        v_valid_q[s1_addr_q] <= 1'b1;
        fwd_v_valid_q        <= 1'b1;
      end
      if (s1_fire && ctrl.res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item_i;
      s1_addr_q <= rd_addr;
    end
    if (c_we) begin
      fwd_c_addr_q <= s1_addr_q;
      fwd_c_q      <= chunk_new;
    end
    if (v_we) begin
      fwd_v_addr_q <= s1_addr_q;
      fwd_v_q      <= voice_new;
    end
    if (s1_fire && ctrl.res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// Voice note attack tracker testbench
// A clocked driver sends trace samples and chunk ends from a queue, and a
// clocked monitor takes chunk reports while both sides idle at random. Each
// transfer into the block updates a local copy of the per-voice trackers,
// which predicts the reports that the monitor compares in order. Phases run
// under several register settings, including the extremes.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vnat_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data  = '0;

  voice_note_attack_tracker_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Local copy of the tracker state and configuration.
  logic signed [15:0] trace_lo [4];
  logic signed [15:0] trace_hi [4];
  bit                 trace_any [4];
  logic [7:0]         env_level [4];
  bit                 gate_was [4];
  logic [31:0]        addr_was [4];
  logic [7:0]         note_gen [4];
  bit                 swing_mode;
  logic [2:0]         active_voices;
  logic [7:0]         attack_thr;
  logic [7:0]         release_amt;

  in_item_t    pending_items [$];
  out_item_t   expected_reports [$];
  out_item_t   wanted_report;
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned send_gap, send_calm, recv_hold, recv_calm;
  int unsigned gen_level [4];
  logic [31:0] gen_addr [4];

  function automatic void clear_trace(int unsigned v);
    trace_lo[v]  = CHUNK_MIN_RESET;
    trace_hi[v]  = CHUNK_MAX_RESET;
    trace_any[v] = 1'b0;
  endfunction

  function automatic void reset_tracker();
    swing_mode    = 1'b1;
    active_voices = 3'd3;
    attack_thr    = 8'd24;
    release_amt   = 8'd3;
    for (int v = 0; v < 4; v++) begin
      clear_trace(v);
      env_level[v] = '0;
      gate_was[v]  = 1'b0;
      addr_was[v]  = '0;
      note_gen[v]  = '0;
      gen_level[v] = 0;
      gen_addr[v]  = '0;
    end
  endfunction

  function automatic void track_item(in_item_t it);
    int unsigned v, swing, amp, prev, floor_lvl;
    bit          retrig;
    out_item_t   rpt;
    v = 32'(it.voice);
    if (v >= VOICE_SLOTS_DEF) return;
    if (it.action == ACT_TRACE_SAMPLE) begin
      if ($signed(it.trace_sample) < trace_lo[v]) trace_lo[v] = it.trace_sample;
      if ($signed(it.trace_sample) > trace_hi[v]) trace_hi[v] = it.trace_sample;
      trace_any[v] = 1'b1;
      return;
    end
    // Chunk ends of inactive voices leave every state untouched.
    if (v >= 32'(active_voices)) return;
    amp = 0;
    if (it.gate) begin
      if (swing_mode) begin
        swing = trace_any[v] ? int'(trace_hi[v]) - int'(trace_lo[v]) : 0;
        amp = swing * 255 / 16384;
        if (amp > 32'(AMP_LIMIT)) amp = 32'(AMP_LIMIT);
      end else begin
        amp = 32'(it.register_volume);
      end
    end
    prev = 32'(env_level[v]);
    retrig = it.gate && (!gate_was[v] || it.sample_address != addr_was[v] ||
                         amp > prev + 32'(attack_thr));
    if (retrig) note_gen[v] = note_gen[v] + 8'd1;
    gate_was[v] = it.gate;
    addr_was[v] = it.sample_address;
    if (retrig || amp == 0) begin
      env_level[v] = 8'(amp);
    end else if (amp >= prev) begin
      env_level[v] = 8'(prev);
    end else begin
      floor_lvl = prev > 32'(release_amt) ? prev - 32'(release_amt) : 0;
      env_level[v] = 8'(amp > floor_lvl ? amp : floor_lvl);
    end
    clear_trace(v);
    rpt.voice_out    = 2'(v);
    rpt.note_pitch   = it.muted ? '0 : it.pitch_value;
    rpt.note_volume  = it.muted ? '0 : env_level[v];
    rpt.note_counter = note_gen[v];
    rpt.retriggered  = retrig;
    expected_reports.push_back(rpt);
  endfunction

  function automatic in_item_t make_sample(int unsigned v, int s);
    in_item_t it;
    it = '0;
    it.action       = ACT_TRACE_SAMPLE;
    it.voice        = 2'(v);
    it.trace_sample = 16'(s);
    return it;
  endfunction

  function automatic in_item_t make_chunk(int unsigned v, bit gate, logic [31:0] addr,
                                          logic [7:0] vol, logic [15:0] pitch, bit muted);
    in_item_t it;
    it = '0;
    it.action          = ACT_CHUNK_END;
    it.voice           = 2'(v);
    it.trace_sample    = 16'($urandom);
    it.gate            = gate;
    it.sample_address  = addr;
    it.register_volume = vol;
    it.pitch_value     = pitch;
    it.muted           = muted;
    return it;
  endfunction

  function automatic int unsigned pick_idle(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Mostly whole chunks with drifting loudness, plus some fully random items.
  task automatic add_random_traffic(int unsigned count);
    int unsigned made, v, n, span, r, lvl;
    int          lo_s, s;
    logic [95:0] noise;
    made = 0;
    while (made < count) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        noise = {$urandom, $urandom, $urandom};
        pending_items.push_back(noise[$bits(in_item_t)-1:0]);
        made++;
      end else begin
        v = $urandom_range(0, 3);
        lvl = gen_level[v];
        if ($urandom_range(0, 99) < 15) lvl = $urandom_range(0, 255);
        else lvl = lvl + $urandom_range(0, 40);
        lvl = lvl < 20 ? 0 : lvl - 20;
        if (lvl > 255) lvl = 255;
        gen_level[v] = lvl;
        n = $urandom_range(0, 6);
        span = lvl * 16384 / 255 + $urandom_range(0, 63);
        if (span > 65535) span = 65535;
        lo_s = int'($urandom_range(0, 65535 - span)) - 32768;
        for (int i = 0; i < n; i++) begin
          if (i == 0) s = lo_s;
          else if (i == 1) s = lo_s + span;
          else s = lo_s + int'($urandom_range(0, span));
          pending_items.push_back(make_sample(v, s));
        end
        if ($urandom_range(0, 99) < 12) gen_addr[v] = $urandom;
        pending_items.push_back(make_chunk(v, $urandom_range(0, 99) < 85, gen_addr[v],
                                           8'(lvl), 16'($urandom),
                                           $urandom_range(0, 99) < 15));
        made += n + 1;
      end
    end
  endtask

  // Holds the sender until every report has come back and the pipe is empty.
  task automatic settle();
    while (pending_items.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(bit swing, int unsigned voices, int unsigned thr,
                              int unsigned rel);
    logic [7:0] vals [4];
    vals[CFG_USE_SWING]        = 8'(swing);
    vals[CFG_VOICE_COUNT]      = 8'(voices);
    vals[CFG_ATTACK_THRESHOLD] = 8'(thr);
    vals[CFG_RELEASE_STEP]     = 8'(rel);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= cfg_reg_e'(i);
      cfg_data  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready);
      case (cfg_reg_e'(i))
        CFG_USE_SWING:        swing_mode    = vals[i][0];
        CFG_VOICE_COUNT:      active_voices = vals[i][2:0];
        CFG_ATTACK_THRESHOLD: attack_thr    = vals[i];
        CFG_RELEASE_STEP:     release_amt   = vals[i];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_gap  = 0;
      send_calm = 0;
    end else begin
      if (in_valid && in_ready) track_item(in_item);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_item  <= pending_items.pop_front();
          in_valid <= 1'b1;
          send_gap  = pick_idle(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      recv_hold  = 0;
      recv_calm  = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: report with nothing pending: voice %0d pitch %h vol %0d cnt %0d rt %0b",
                     $realtime, out_item.voice_out, out_item.note_pitch, out_item.note_volume,
                     out_item.note_counter, out_item.retriggered);
        end else begin
          wanted_report = expected_reports.pop_front();
          if (out_item.voice_out !== wanted_report.voice_out ||
              out_item.note_pitch !== wanted_report.note_pitch ||
              out_item.note_volume !== wanted_report.note_volume ||
              out_item.note_counter !== wanted_report.note_counter ||
              out_item.retriggered !== wanted_report.retriggered) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: report mismatch: expected voice %0d pitch %h vol %0d cnt %0d ",
                        "rt %0b, got voice %0d pitch %h vol %0d cnt %0d rt %0b"},
                       $realtime, wanted_report.voice_out, wanted_report.note_pitch,
                       wanted_report.note_volume, wanted_report.note_counter,
                       wanted_report.retriggered, out_item.voice_out, out_item.note_pitch,
                       out_item.note_volume, out_item.note_counter, out_item.retriggered);
          end
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        recv_hold  = pick_idle(recv_calm);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    reset_tracker();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full-scale swing saturates the amplitude; the gate rise retriggers.
    pending_items.push_back(make_sample(0, -32768));
    pending_items.push_back(make_sample(0, 32767));
    pending_items.push_back(make_chunk(0, 1'b1, 32'h0, 8'h00, 16'hffff, 1'b0));
    // A chunk without samples has no swing.
    pending_items.push_back(make_chunk(1, 1'b1, 32'hffff_ffff, 8'hff, 16'h0000, 1'b0));
    // A small swing lets the envelope decay by the release step; a chunk without samples then drops it to zero.
    pending_items.push_back(make_sample(0, -100));
    pending_items.push_back(make_sample(0, 100));
    pending_items.push_back(make_chunk(0, 1'b1, 32'h0, 8'h10, 16'h1234, 1'b0));
    pending_items.push_back(make_chunk(0, 1'b1, 32'h0, 8'h10, 16'h1234, 1'b0));
    // A new sample address retriggers.
    pending_items.push_back(make_chunk(0, 1'b1, 32'h1, 8'h10, 16'h4321, 1'b0));
    // Gate off, then a muted gate rise.
    pending_items.push_back(make_sample(2, 0));
    pending_items.push_back(make_chunk(2, 1'b0, 32'h5555_aaaa, 8'h80, 16'h1234, 1'b1));
    pending_items.push_back(make_chunk(2, 1'b1, 32'h5555_aaaa, 8'h80, 16'hbeef, 1'b1));
    // Voice 3 is inactive, so its chunk end is dropped and its samples stay.
    pending_items.push_back(make_sample(3, 5000));
    pending_items.push_back(make_sample(3, -5000));
    pending_items.push_back(make_chunk(3, 1'b1, 32'h0, 8'h40, 16'h0100, 1'b0));
    // Attack above the envelope, then a rise within the threshold holds.
    pending_items.push_back(make_sample(1, -2000));
    pending_items.push_back(make_sample(1, 2000));
    pending_items.push_back(make_chunk(1, 1'b1, 32'hffff_ffff, 8'h00, 16'h0200, 1'b0));
    pending_items.push_back(make_sample(1, -2100));
    pending_items.push_back(make_sample(1, 2100));
    pending_items.push_back(make_chunk(1, 1'b1, 32'hffff_ffff, 8'h00, 16'h0300, 1'b0));
    settle();

    write_config(1'b0, 4, 0, 0);
    pending_items.push_back(make_chunk(3, 1'b1, 32'h0, 8'hff, 16'h0100, 1'b0));
    add_random_traffic(100);
    settle();

    write_config(1'b1, 4, 255, 255);
    add_random_traffic(90);
    settle();

    write_config(1'b1, 1, 40, 7);
    add_random_traffic(70);
    settle();

    write_config(1'b0, 0, 24, 3);
    add_random_traffic(25);
    settle();

    write_config(1'b1, 2, $urandom_range(0, 255), $urandom_range(0, 255));
    add_random_traffic(45);
    settle();
    add_random_traffic(45);
    settle();

    write_config(1'b0, 3, $urandom_range(0, 255), $urandom_range(0, 255));
    add_random_traffic(90);
    settle();

    write_config(1'b1, 4, 24, 3);
    add_random_traffic(80);
    settle();

    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
